// ----- hw/rtl/lcd_panel_timing_generator_defines.svh -----
// Assertion helpers shared by the RTL. All properties sample on clk and are
// disabled while rst is high.
`ifndef LCD_PANEL_TIMING_GENERATOR_DEFINES_SVH
`define LCD_PANEL_TIMING_GENERATOR_DEFINES_SVH

// cond implies prop in the same cycle
`define LCDTG_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// cond implies prop in the next cycle
`define LCDTG_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- hw/rtl/lcdtg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lcdtg_pkg;

  // default counter widths
  localparam int DEFAULT_LINE_BITS  = 12;
  localparam int DEFAULT_FRAME_BITS = 24;

  // register field widths
  localparam int LREG_W = 12;
  localparam int FREG_W = 24;

  // APB geometry
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // register indexes
  localparam logic [2:0] REG_LINE_PERIOD  = 3'd0;
  localparam logic [2:0] REG_HSYNC_WIDTH  = 3'd1;
  localparam logic [2:0] REG_FRAME_PERIOD = 3'd2;
  localparam logic [2:0] REG_VSYNC_WIDTH  = 3'd3;
  localparam logic [2:0] REG_H_WINDOW     = 3'd4;
  localparam logic [2:0] REG_V_START      = 3'd5;
  localparam logic [2:0] REG_V_END        = 3'd6;
  localparam logic [2:0] REG_POLARITY     = 3'd7;

  // polarity bits
  localparam int POL_HSYNC = 0;
  localparam int POL_VSYNC = 1;
  localparam int POL_DE    = 2;

  typedef struct packed {
    logic [LREG_W-1:0] line_period;
    logic [LREG_W-1:0] hsync_width;
    logic [FREG_W-1:0] frame_period;
    logic [FREG_W-1:0] vsync_width;
    logic [LREG_W-1:0] h_end;
    logic [LREG_W-1:0] h_start;
    logic [FREG_W-1:0] v_start;
    logic [FREG_W-1:0] v_end;
    logic [2:0]        polarity;
  } lcdtg_cfg_t;

  // per-tick timing flags before polarity
  typedef struct packed {
    logic hsync;
    logic vsync;
    logic de;
    logic frame_start;
    logic line_start;
  } lcdtg_flags_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lcdtg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lcdtg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcdtg_pkg::ADDR_W-1:0] paddr,
  input  logic [lcdtg_pkg::DATA_W-1:0] pwdata,
  output logic [lcdtg_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output lcdtg_pkg::lcdtg_cfg_t       cfg
);
  import lcdtg_pkg::*;

  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_period  <= LREG_W'(1);
      cfg.hsync_width  <= '0;
      cfg.frame_period <= FREG_W'(1);
      cfg.vsync_width  <= '0;
      cfg.h_end        <= '0;
      cfg.h_start      <= '0;
      cfg.v_start      <= '0;
      cfg.v_end        <= '0;
      cfg.polarity     <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LINE_PERIOD:  cfg.line_period  <= pwdata[LREG_W-1:0];
        REG_HSYNC_WIDTH:  cfg.hsync_width  <= pwdata[LREG_W-1:0];
        REG_FRAME_PERIOD: cfg.frame_period <= pwdata[FREG_W-1:0];
        REG_VSYNC_WIDTH:  cfg.vsync_width  <= pwdata[FREG_W-1:0];
        REG_H_WINDOW: begin
          cfg.h_start <= pwdata[LREG_W-1:0];
          cfg.h_end   <= pwdata[16+LREG_W-1:16];
        end
        REG_V_START:      cfg.v_start      <= pwdata[FREG_W-1:0];
        REG_V_END:        cfg.v_end        <= pwdata[FREG_W-1:0];
        REG_POLARITY:     cfg.polarity     <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_LINE_PERIOD:  prdata = DATA_W'(cfg.line_period);
      REG_HSYNC_WIDTH:  prdata = DATA_W'(cfg.hsync_width);
      REG_FRAME_PERIOD: prdata = DATA_W'(cfg.frame_period);
      REG_VSYNC_WIDTH:  prdata = DATA_W'(cfg.vsync_width);
      REG_H_WINDOW:     prdata = {4'b0, cfg.h_end, 4'b0, cfg.h_start};
      REG_V_START:      prdata = DATA_W'(cfg.v_start);
      REG_V_END:        prdata = DATA_W'(cfg.v_end);
      REG_POLARITY:     prdata = DATA_W'(cfg.polarity);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lcdtg_timing.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lcdtg_timing #(
  parameter int LINE_BITS  = lcdtg_pkg::DEFAULT_LINE_BITS,
  parameter int FRAME_BITS = lcdtg_pkg::DEFAULT_FRAME_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lcdtg_pkg::lcdtg_cfg_t   cfg,
  input  logic                    run,
  input  logic                    advance,
  output lcdtg_pkg::lcdtg_flags_t flags
);
  import lcdtg_pkg::*;

  // compare widths: wide enough for count, register and count + 1
  localparam int LC_W = ((LINE_BITS > LREG_W) ? LINE_BITS : LREG_W) + 1;
  localparam int FC_W = ((FRAME_BITS > FREG_W) ? FRAME_BITS : FREG_W) + 1;

  logic [LINE_BITS-1:0]  line_count;
  logic [LINE_BITS-1:0]  line_count_next;
  logic [FRAME_BITS-1:0] frame_count;
  logic [FRAME_BITS-1:0] frame_count_next;

  logic [LC_W-1:0] lc_x, lc_inc;
  logic [FC_W-1:0] fc_x, fc_inc;
  logic            h_in, v_in;

  assign lc_x   = LC_W'(line_count);
  assign fc_x   = FC_W'(frame_count);
  assign lc_inc = lc_x + LC_W'(1);
  assign fc_inc = fc_x + FC_W'(1);

  // window tests on the current counts
  assign h_in = (lc_x >= LC_W'(cfg.h_start)) && (lc_x <= LC_W'(cfg.h_end));
  assign v_in = (fc_x >= FC_W'(cfg.v_start)) && (fc_x <= FC_W'(cfg.v_end));

  always_comb begin
    flags.hsync       = run && (lc_x < LC_W'(cfg.hsync_width));
    flags.vsync       = run && (fc_x < FC_W'(cfg.vsync_width));
    flags.de          = run && h_in && v_in;
    flags.frame_start = run && (frame_count == '0);
    flags.line_start  = run && (line_count == '0);
  end

  // wrap once count + 1 reaches the period; a zero period keeps the count at 0
  always_comb begin
    if (!run || (lc_inc >= LC_W'(cfg.line_period))) begin
      line_count_next = '0;
    end else begin
      line_count_next = lc_inc[LINE_BITS-1:0];
    end
    if (!run || (fc_inc >= FC_W'(cfg.frame_period))) begin
      frame_count_next = '0;
    end else begin
      frame_count_next = fc_inc[FRAME_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count  <= '0;
      frame_count <= '0;
    end else if (advance) begin
      line_count  <= line_count_next;
      frame_count <= frame_count_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lcd_panel_timing_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Parallel RGB panel timing generator.
// Input channel (in_valid / in_stall / run): one beat per pixel-clock tick.
// run = 1 advances the line and frame counters; run = 0 clears both and the
// tick's pins show their inactive (polarity) levels.
// Output channel (out_valid / out_stall): one result beat per input beat,
// in order, carrying hsync, vsync and data-enable pin levels after polarity
// plus the frame_start / line_start markers.
// A beat enters the input register on acceptance and its result moves into the
// output register once that register is empty or its result has been taken.
// Throughput: one beat per cycle while out_stall is low, set by the single counter-update stage.
// When the receiver stalls, the result holds; the input register still takes
// one more beat, after which in_stall rises until the output drains.
// Reset (rst, synchronous): counters clear to 0, both periods reset to 1 and
// the other config registers to 0; both pipeline stages empty.
// Configuration: APB registers at byte address 4*index, pready always high;
// write only while no beat is in flight.
module lcd_panel_timing_generator #(
  parameter int LINE_BITS  = lcdtg_pkg::DEFAULT_LINE_BITS,
  parameter int FRAME_BITS = lcdtg_pkg::DEFAULT_FRAME_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  // config port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lcdtg_pkg::ADDR_W-1:0] paddr,
  input  logic [lcdtg_pkg::DATA_W-1:0] pwdata,
  output logic [lcdtg_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  // tick input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         run,
  // result output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hsync_level,
  output logic                         vsync_level,
  output logic                         data_enable_level,
  output logic                         frame_start,
  output logic                         line_start
);
  import lcdtg_pkg::*;

  lcdtg_cfg_t   cfg;
  lcdtg_flags_t flags;

  logic s1_valid;
  logic s1_run;
  logic out_load;
  logic in_load;

  lcdtg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake: output register frees when empty or taken
  assign out_load = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !out_load;
  assign in_load  = in_valid && !in_stall;

  lcdtg_timing #(
    .LINE_BITS  (LINE_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_timing (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .run     (s1_run),
    .advance (out_load),
    .flags   (flags)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_load) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      s1_run <= run;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hsync_level       <= flags.hsync ^ cfg.polarity[POL_HSYNC];
      vsync_level       <= flags.vsync ^ cfg.polarity[POL_VSYNC];
      data_enable_level <= flags.de ^ cfg.polarity[POL_DE];
      frame_start       <= flags.frame_start;
      line_start        <= flags.line_start;
    end
  end

  // checks
`include "lcd_panel_timing_generator_defines.svh"

  `LCDTG_ASSERT_NOW(a_stall_needs_beat, in_stall, s1_valid, "input stalled with empty stage")
  `LCDTG_ASSERT_NEXT(a_result_follows, out_load, out_valid, "computed beat did not show")
  `LCDTG_ASSERT_NEXT(a_idle_clears, out_load && !s1_run,
    !s1_valid || !s1_run || (flags.frame_start && flags.line_start),
    "counters not cleared after idle tick")

endmodule

`default_nettype wire
